// File: hdl/rtfp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the radar target frame parser
// no dependencies; used by rtfp_ctrl, rtfp_datapath and the top level
package rtfp_pkg;

  localparam int WinLen = 30;

  localparam logic [7:0] Hdr0  = 8'hAA;
  localparam logic [7:0] Hdr1  = 8'hFF;
  localparam logic [7:0] Hdr2  = 8'h03;
  localparam logic [7:0] Hdr3  = 8'h00;
  localparam logic [7:0] Tail0 = 8'h55;
  localparam logic [7:0] Tail1 = 8'hCC;

  localparam logic [1:0]  LastSlot    = 2'd2;
  localparam logic [31:0] SqrtBitInit = 32'h4000_0000;

  typedef struct packed {
    logic       shift;      // take rx_byte into the window
    logic       mul_first;  // square of x into the accumulator
    logic       mul_add;    // add square of y, start the root
    logic       sqrt_step;  // one root digit
    logic       out_load;   // fill the result register
    logic [1:0] slot;       // target slot being worked on
  } rtfp_cmd_t;

  typedef struct packed {
    logic frame_match;
    logic sqrt_last;
  } rtfp_status_t;

endpackage

// File: hdl/rtfp_datapath.sv
`timescale 1ns / 1ps
// byte window, slot selection, square and integer root unit, result register
// depends on rtfp_pkg
module rtfp_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  rtfp_pkg::rtfp_cmd_t      cmd,
  output rtfp_pkg::rtfp_status_t   status,
  input  logic [7:0]               rx_byte,
  output logic [1:0]               target_number,
  output logic                     target_valid,
  output logic signed [15:0]       x_pos,
  output logic signed [15:0]       y_pos,
  output logic signed [15:0]       radial_speed,
  output logic [15:0]              range_dist,
  output logic [1:0]               valid_count,
  output logic                     last_target
);

  logic [7:0]  win [rtfp_pkg::WinLen];
  logic [15:0] x_raw, y_raw, s_raw, op, mag;
  logic        v0, v1, v2, cur_valid;
  logic [1:0]  cnt;
  logic [31:0] prod, acc, rad, root, sbit, trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rtfp_pkg::WinLen; i++) win[i] <= 8'h00;
    end else if (cmd.shift) begin
      for (int i = 0; i < rtfp_pkg::WinLen - 1; i++) win[i] <= win[i + 1];
      win[rtfp_pkg::WinLen - 1] <= rx_byte;
    end
  end

  assign status.frame_match = (win[0] == rtfp_pkg::Hdr0) && (win[1] == rtfp_pkg::Hdr1) &&
                              (win[2] == rtfp_pkg::Hdr2) && (win[3] == rtfp_pkg::Hdr3) &&
                              (win[rtfp_pkg::WinLen - 2] == rtfp_pkg::Tail0) &&
                              (win[rtfp_pkg::WinLen - 1] == rtfp_pkg::Tail1);

  // a target counts when x or y is nonzero
  assign v0 = ({win[5], win[4]} != 16'd0) || ({win[7], win[6]} != 16'd0);
  assign v1 = ({win[13], win[12]} != 16'd0) || ({win[15], win[14]} != 16'd0);
  assign v2 = ({win[21], win[20]} != 16'd0) || ({win[23], win[22]} != 16'd0);
  assign cnt = {1'b0, v0} + {1'b0, v1} + {1'b0, v2};

  always_comb begin
    case (cmd.slot)
      2'd1: begin
        x_raw = {win[13], win[12]};
        y_raw = {win[15], win[14]};
        s_raw = {win[17], win[16]};
        cur_valid = v1;
      end
      2'd2: begin
        x_raw = {win[21], win[20]};
        y_raw = {win[23], win[22]};
        s_raw = {win[25], win[24]};
        cur_valid = v2;
      end
      default: begin
        x_raw = {win[5], win[4]};
        y_raw = {win[7], win[6]};
        s_raw = {win[9], win[8]};
        cur_valid = v0;
      end
    endcase
  end

  // magnitude of a two's complement value; 0x8000 maps to 0x8000
  assign op    = cmd.mul_first ? x_raw : y_raw;
  assign mag   = op[15] ? (~op + 16'd1) : op;
  assign prod  = 32'(mag) * 32'(mag);
  assign trial = root + sbit;

  assign status.sqrt_last = sbit[0];

  always_ff @(posedge clk) begin
    if (cmd.mul_first) begin
      acc <= prod;
    end
    if (cmd.mul_add) begin
      rad  <= acc + prod;
      root <= 32'd0;
      sbit <= rtfp_pkg::SqrtBitInit;
    end else if (cmd.sqrt_step) begin
      if (rad >= trial) begin
        rad  <= rad - trial;
        root <= (root >> 1) + sbit;
      end else begin
        root <= root >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      target_number <= cmd.slot + 2'd1;
      target_valid  <= cur_valid;
      x_pos         <= $signed(x_raw);
      y_pos         <= $signed(y_raw);
      radial_speed  <= $signed(s_raw);
      range_dist    <= root[15:0];
      valid_count   <= cnt;
      last_target   <= (cmd.slot == rtfp_pkg::LastSlot);
    end
  end

endmodule

// File: hdl/rtfp_ctrl.sv
`timescale 1ns / 1ps
// sequencer: byte intake, frame check and the per-target square, root and load steps
// depends on rtfp_pkg
module rtfp_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  rtfp_pkg::rtfp_status_t  status,
  output rtfp_pkg::rtfp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SQRT,
    ST_LOAD
  } state_t;

  state_t     state;
  logic [1:0] slot;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.slot      = slot;
    cmd.shift     = (state == ST_IDLE) && in_valid;
    cmd.mul_first = (state == ST_MUL_X);
    cmd.mul_add   = (state == ST_MUL_Y);
    cmd.sqrt_step = (state == ST_SQRT);
    cmd.out_load  = (state == ST_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      // a new beat is loaded, or the held beat stays until taken
      out_valid <= ((state == ST_LOAD) && out_free) || (out_valid && !out_ready);
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_CHECK;
        end
        ST_CHECK: begin
          slot  <= 2'd0;
          state <= status.frame_match ? ST_MUL_X : ST_IDLE;
        end
        ST_MUL_X: state <= ST_MUL_Y;
        ST_MUL_Y: state <= ST_SQRT;
        ST_SQRT: begin
          if (status.sqrt_last) state <= ST_LOAD;
        end
        ST_LOAD: begin
          // result register must be empty or emptying this cycle
          if (out_free) begin
            if (slot == rtfp_pkg::LastSlot) begin
              state <= ST_IDLE;
            end else begin
              slot  <= slot + 2'd1;
              state <= ST_MUL_X;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/radar_target_frame_parser.sv
`timescale 1ns / 1ps
// Each accepted byte enters a 30-byte sliding window; a byte that does not
// complete a frame (header AA FF 03 00, tail 55 CC) goes through intake
// and check. A byte that completes a frame yields three result beats, one per
// target; each target goes through x*x and y*y on the shared 16x16
// multiplier, the one-digit-per-cycle integer root and one load; the load
// waits while the result register is full.
// The result register holds the last beat while the next byte is taken.
// depends on rtfp_pkg, rtfp_ctrl, rtfp_datapath
module radar_target_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         target_number,
  output logic               target_valid,
  output logic signed [15:0] x_pos,
  output logic signed [15:0] y_pos,
  output logic signed [15:0] radial_speed,
  output logic [15:0]        range_dist,
  output logic [1:0]         valid_count,
  output logic               last_target
);

  rtfp_pkg::rtfp_cmd_t    cmd;
  rtfp_pkg::rtfp_status_t status;

  rtfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rtfp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .rx_byte       (rx_byte),
    .target_number (target_number),
    .target_valid  (target_valid),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .radial_speed  (radial_speed),
    .range_dist    (range_dist),
    .valid_count   (valid_count),
    .last_target   (last_target)
  );

endmodule

// File: sim/tb_radar_target_frame_parser.sv
`timescale 1ns / 1ps
// self-checking bench for radar_target_frame_parser: serial bytes in, target beats out,
// every beat checked against a sliding-window model kept inside the bench or against a typed row
// depends on rtfp_pkg and the radar_target_frame_parser rtl
module tb_radar_target_frame_parser;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;
  localparam logic [15:0] TailWord = {rtfp_pkg::Tail0, rtfp_pkg::Tail1};

  typedef struct packed {
    logic [1:0]  number;
    logic        valid;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] speed;
    logic [15:0] rng;
    logic [1:0]  count;
    logic        last;
  } target_t;

  typedef struct packed {
    logic [7:0]       lead;   // noise bytes ahead of the frame
    logic [7:0]       skip;   // frame bytes already sitting in the window
    logic [15:0]      tail;
    logic [0:2][15:0] x;
    logic [0:2][15:0] y;
    logic [0:2][15:0] speed;
    logic             known;  // typed expectation below is used
    logic [0:2]       valid;
    logic [0:2][15:0] rng;
    logic [1:0]       count;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] target_number;
  logic target_valid;
  logic signed [15:0] x_pos;
  logic signed [15:0] y_pos;
  logic signed [15:0] radial_speed;
  logic [15:0] range_dist;
  logic [1:0] valid_count;
  logic last_target;

  logic [7:0] rx_window [0:rtfp_pkg::WinLen-1];
  logic [7:0] image [0:rtfp_pkg::WinLen-1];
  target_t frame_targets [0:2];
  target_t typed_targets [0:2];
  target_t targets_due [$];
  frame_row_t rows [$];
  logic typed_armed = 1'b0;
  logic calm = 1'b0;
  int fails = 0;
  int cycles = 0;
  int holds_asked = 0;
  int bytes_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radar_target_frame_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .target_number (target_number),
    .target_valid  (target_valid),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .radial_speed  (radial_speed),
    .range_dist    (range_dist),
    .valid_count   (valid_count),
    .last_target   (last_target)
  );

  function automatic logic [15:0] root_of(input logic [31:0] v);
    logic [15:0] r;
    logic [63:0] t;
    r = 16'd0;
    for (int b = 15; b >= 0; b--) begin
      t = {48'd0, r | (16'd1 << b)};
      if (t * t <= {32'd0, v}) r = t[15:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] square_of(input logic [15:0] raw);
    logic [16:0] m;
    logic [33:0] sq;
    m = raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
    sq = {17'd0, m} * {17'd0, m};
    return sq[31:0];
  endfunction

  // shifts one byte into the window; on a frame the three targets land in frame_targets
  function automatic logic take_byte(input logic [7:0] b);
    logic [15:0] x, y, s;
    logic [1:0] n;
    int p;
    for (int i = 0; i < rtfp_pkg::WinLen - 1; i++) rx_window[i] = rx_window[i + 1];
    rx_window[rtfp_pkg::WinLen - 1] = b;
    if (!(rx_window[0] == rtfp_pkg::Hdr0 && rx_window[1] == rtfp_pkg::Hdr1 &&
          rx_window[2] == rtfp_pkg::Hdr2 && rx_window[3] == rtfp_pkg::Hdr3 &&
          rx_window[28] == rtfp_pkg::Tail0 && rx_window[29] == rtfp_pkg::Tail1))
      return 1'b0;
    n = 2'd0;
    for (int k = 0; k < 3; k++) begin
      p = 4 + 8 * k;
      x = {rx_window[p + 1], rx_window[p]};
      y = {rx_window[p + 3], rx_window[p + 2]};
      s = {rx_window[p + 5], rx_window[p + 4]};
      frame_targets[k].number = 2'(k + 1);
      frame_targets[k].valid  = (x != 16'd0) || (y != 16'd0);
      frame_targets[k].x      = x;
      frame_targets[k].y      = y;
      frame_targets[k].speed  = s;
      frame_targets[k].rng    = root_of(square_of(x) + square_of(y));
      frame_targets[k].last   = (k == 2);
      n = n + {1'b0, frame_targets[k].valid};
    end
    for (int k = 0; k < 3; k++) frame_targets[k].count = n;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_coord();
    int c;
    c = $urandom_range(0, 99);
    if (c < 25) return 16'h0000;
    if (c < 35) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic frame_row_t frame_entry(
    input int lead, input int skip, input logic [15:0] tail, input logic known,
    input logic [15:0] x0, y0, s0, x1, y1, s1, x2, y2, s2,
    input logic [2:0] v, input logic [15:0] r0, r1, r2, input logic [1:0] cnt);
    frame_row_t r;
    r.lead  = 8'(lead);
    r.skip  = 8'(skip);
    r.tail  = tail;
    r.known = known;
    r.x     = {x0, x1, x2};
    r.y     = {y0, y1, y2};
    r.speed = {s0, s1, s2};
    r.valid = v;
    r.rng   = {r0, r1, r2};
    r.count = cnt;
    return r;
  endfunction

  function automatic void fill_image(input frame_row_t r);
    int p;
    image[0] = rtfp_pkg::Hdr0;
    image[1] = rtfp_pkg::Hdr1;
    image[2] = rtfp_pkg::Hdr2;
    image[3] = rtfp_pkg::Hdr3;
    for (int k = 0; k < 3; k++) begin
      p = 4 + 8 * k;
      image[p]     = r.x[k][7:0];
      image[p + 1] = r.x[k][15:8];
      image[p + 2] = r.y[k][7:0];
      image[p + 3] = r.y[k][15:8];
      image[p + 4] = r.speed[k][7:0];
      image[p + 5] = r.speed[k][15:8];
      image[p + 6] = 8'($urandom);
      image[p + 7] = 8'($urandom);
    end
    image[28] = r.tail[15:8];
    image[29] = r.tail[7:0];
  endfunction

  task automatic note_fail(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) note_fail($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_target();
    target_t want;
    if (targets_due.size() == 0) begin
      note_fail($sformatf("target beat %0d with nothing pending", target_number));
      return;
    end
    want = targets_due.pop_front();
    check_field("target_number", {14'd0, target_number}, {14'd0, want.number});
    check_field("target_valid", {15'd0, target_valid}, {15'd0, want.valid});
    check_field("x_pos", x_pos, want.x);
    check_field("y_pos", y_pos, want.y);
    check_field("radial_speed", radial_speed, want.speed);
    check_field("range_dist", range_dist, want.rng);
    check_field("valid_count", {14'd0, valid_count}, {14'd0, want.count});
    check_field("last_target", {15'd0, last_target}, {15'd0, want.last});
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 30) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (take_byte(b)) begin
      for (int k = 0; k < 3; k++)
        targets_due.push_back(typed_armed ? typed_targets[k] : frame_targets[k]);
    end
  endtask

  // tamper flips one bit of a header or tail byte
  task automatic send_frame(input frame_row_t r, input logic tamper);
    int sel;
    if (r.known) begin
      for (int k = 0; k < 3; k++) begin
        typed_targets[k].number = 2'(k + 1);
        typed_targets[k].valid  = r.valid[k];
        typed_targets[k].x      = r.x[k];
        typed_targets[k].y      = r.y[k];
        typed_targets[k].speed  = r.speed[k];
        typed_targets[k].rng    = r.rng[k];
        typed_targets[k].count  = r.count;
        typed_targets[k].last   = (k == 2);
      end
    end
    repeat (r.lead) send_byte(8'($urandom_range(0, 255)));
    fill_image(r);
    if (tamper) begin
      sel = $urandom_range(0, 5);
      if (sel > 3) sel = sel + 24;
      image[sel] = image[sel] ^ (8'd1 << $urandom_range(0, 7));
    end
    for (int i = int'(r.skip); i < rtfp_pkg::WinLen; i++) begin
      typed_armed = r.known && (i == rtfp_pkg::WinLen - 1);
      send_byte(image[i]);
    end
    typed_armed = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check, then pick ready for the next cycle
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_target();
      if (holds_asked != holds_done) begin
        holds_done = holds_asked;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin
    frame_row_t r;
    int iter;
    int pick;
    foreach (rx_window[i]) rx_window[i] = 8'h00;

    // only a tail after reset: the zero fill cannot pass for a header
    rows.push_back(frame_entry(0, 28, TailWord, 1'b0,
                               16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                               16'd0, 16'd0, 16'd0,
                               3'b000, 16'd0, 16'd0, 16'd0, 2'd0));
    rows.push_back(frame_entry(0, 0, TailWord, 1'b1,
                               16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                               16'd0, 16'd0, 16'd0,
                               3'b000, 16'd0, 16'd0, 16'd0, 2'd0));
    // largest sum of squares
    rows.push_back(frame_entry(0, 0, TailWord, 1'b1,
                               16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                               16'h8000, 16'h8000, 16'h0000,
                               3'b111, 16'd46340, 16'd46340, 16'd46340, 2'd3));
    rows.push_back(frame_entry(0, 0, TailWord, 1'b1,
                               16'h7FFF, 16'h0000, 16'h0001, 16'h0000, 16'h8000, 16'hFFFF,
                               16'h0003, 16'h0004, 16'h8000,
                               3'b111, 16'd32767, 16'd32768, 16'd5, 2'd3));
    rows.push_back(frame_entry(0, 0, TailWord, 1'b1,
                               16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF,
                               16'hFFFF, 16'hFFFF, 16'h1234,
                               3'b101, 16'd1, 16'd0, 16'd1, 2'd2));
    rows.push_back(frame_entry(3, 0, TailWord, 1'b1,
                               16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
                               16'hFFFF, 16'h0000, 16'h8000,
                               3'b001, 16'd0, 16'd0, 16'd1, 2'd1));
    rows.push_back(frame_entry(5, 0, TailWord, 1'b0,
                               16'h7FFF, 16'h7FFF, 16'h5A5A, 16'h8000, 16'h7FFF, 16'hA5A5,
                               16'h00FF, 16'hFF00, 16'h0F0F,
                               3'b000, 16'd0, 16'd0, 16'd0, 2'd0));
    // wrong second tail byte, no frame
    rows.push_back(frame_entry(0, 0, {rtfp_pkg::Tail0, 8'hCD}, 1'b0,
                               16'h1234, 16'h5678, 16'h9ABC, 16'h0001, 16'h0002, 16'h0003,
                               16'h0004, 16'h0005, 16'h0006,
                               3'b000, 16'd0, 16'd0, 16'd0, 2'd0));
    // second slot carries a header, so twelve more bytes make an overlapping frame
    rows.push_back(frame_entry(0, 0, TailWord, 1'b0,
                               16'h1111, 16'h2222, 16'h3333, 16'hFFAA, 16'h0003, 16'h4444,
                               16'h5555, 16'h6666, 16'h7777,
                               3'b000, 16'd0, 16'd0, 16'd0, 2'd0));
    rows.push_back(frame_entry(0, 18, TailWord, 1'b0,
                               16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                               16'h1000, 16'hF000, 16'h55AA,
                               3'b000, 16'd0, 16'd0, 16'd0, 2'd0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // long receiver hold over the first frames so the input stalls
    holds_asked++;
    foreach (rows[i]) send_frame(rows[i], 1'b0);

    iter = 0;
    while (bytes_sent < 380 || iter < 5) begin
      if (iter == 1) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (targets_due.size() != 0);
      end
      calm = (iter >= 2 && iter < 5);
      r = frame_entry($urandom_range(0, 3), 0, TailWord, 1'b0,
                      pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord(),
                      3'b000, 16'd0, 16'd0, 16'd0, 2'd0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 99) < 15) begin
          r.x[1] = {rtfp_pkg::Hdr1, rtfp_pkg::Hdr0};
          r.y[1] = {rtfp_pkg::Hdr3, rtfp_pkg::Hdr2};
          send_frame(r, 1'b0);
          r.lead = 8'd0;
          r.skip = 8'd18;
          r.x[2] = pick_coord();
          r.y[2] = pick_coord();
          r.speed[2] = pick_coord();
        end
        send_frame(r, 1'b0);
      end else if (pick < 85) begin
        send_frame(r, 1'b1);
      end else begin
        repeat ($urandom_range(5, 20)) send_byte(8'($urandom_range(0, 255)));
      end
      iter++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (targets_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rtfp_pkg.sv
hdl/rtfp_datapath.sv
hdl/rtfp_ctrl.sv
hdl/radar_target_frame_parser.sv
sim/tb_radar_target_frame_parser.sv
